// File: design/pidff_pkg.sv
`default_nettype none
package pidff_pkg;

    // Fixed data path widths.
    localparam int DATA_BITS = 16;
    localparam int FRAC_BITS = 8;
    localparam int ACC_BITS  = 32;
    localparam int GAIN_BITS = 16;
    localparam int CFG_BITS  = 16;
    localparam bit INVERTED  = 1'b0;

    // Error, error difference and the wide working width that holds every
    // exact product and the sum of four accumulator terms.
    localparam int ERR_BITS  = DATA_BITS + 1;
    localparam int DIFF_BITS = ERR_BITS + 1;
    localparam int WIDE_BITS = GAIN_BITS + DIFF_BITS + 2;

    typedef logic [1:0]                  func_t;
    typedef logic [2:0]                  reg_idx_t;
    typedef logic        [GAIN_BITS-1:0] gain_t;
    typedef logic signed [DATA_BITS-1:0] data_t;
    typedef logic signed [ERR_BITS-1:0]  err_t;
    typedef logic signed [DIFF_BITS-1:0] diff_t;
    typedef logic signed [ACC_BITS-1:0]  acc_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;

    localparam func_t FUNC_SAMPLE  = 2'd0;
    localparam func_t FUNC_ENABLE  = 2'd1;
    localparam func_t FUNC_DISABLE = 2'd2;

    localparam reg_idx_t REG_GAIN_P    = 3'd0;
    localparam reg_idx_t REG_GAIN_I    = 3'd1;
    localparam reg_idx_t REG_GAIN_D    = 3'd2;
    localparam reg_idx_t REG_GAIN_F    = 3'd3;
    localparam reg_idx_t REG_DRIVE_MIN = 3'd4;
    localparam reg_idx_t REG_DRIVE_MAX = 3'd5;
    localparam reg_idx_t REG_INTEG_MIN = 3'd6;
    localparam reg_idx_t REG_INTEG_MAX = 3'd7;

    localparam data_t DATA_MIN = {1'b1, {(DATA_BITS-1){1'b0}}};
    localparam data_t DATA_MAX = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam acc_t  ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};
    localparam acc_t  ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};

    typedef struct packed {
        func_t func;
        data_t setpoint;
        data_t measurement;
        data_t preload;
    } in_beat_t;

    typedef struct packed {
        data_t drive;
        acc_t  p_term;
        acc_t  i_term;
        acc_t  d_term;
        acc_t  f_term;
    } out_beat_t;

    typedef struct packed {
        gain_t gain_p;
        gain_t gain_i;
        gain_t gain_d;
        gain_t gain_f;
        data_t drive_min;
        data_t drive_max;
        data_t integ_min;
        data_t integ_max;
    } cfg_t;

    // Second stage payload: saturated P, D and F terms and the raw integral
    // increment, plus the preload for an enable.
    typedef struct packed {
        acc_t  p_term;
        wide_t i_prod;
        acc_t  d_term;
        acc_t  f_term;
        data_t preload;
    } stage2_t;

    typedef struct packed {
        acc_t p_term;
        acc_t i_term;
        acc_t d_term;
        acc_t f_term;
    } terms_t;

    typedef struct packed {
        logic running;
        logic gains_zero;
    } front_stat_t;

    // Saturate a wide signed value to the accumulator width.
    function automatic acc_t sat_acc(input wide_t x);
        acc_t r;
        if (!x[WIDE_BITS-1] && (|x[WIDE_BITS-2:ACC_BITS-1])) begin
            r = ACC_MAX;
        end else if (x[WIDE_BITS-1] && !(&x[WIDE_BITS-2:ACC_BITS-1])) begin
            r = ACC_MIN;
        end else begin
            r = x[ACC_BITS-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/pidff_cfg_regs.sv
`default_nettype none
module pidff_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    input  wire pidff_pkg::reg_idx_t               cfg_index,
    input  wire logic [pidff_pkg::CFG_BITS-1:0]    cfg_data,
    output pidff_pkg::cfg_t                        cfg
);

    pidff_pkg::cfg_t cfg_reg;
    pidff_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                pidff_pkg::REG_GAIN_P:
                    cfg_next.gain_p = cfg_data[pidff_pkg::GAIN_BITS-1:0];
                pidff_pkg::REG_GAIN_I:
                    cfg_next.gain_i = cfg_data[pidff_pkg::GAIN_BITS-1:0];
                pidff_pkg::REG_GAIN_D:
                    cfg_next.gain_d = cfg_data[pidff_pkg::GAIN_BITS-1:0];
                pidff_pkg::REG_GAIN_F:
                    cfg_next.gain_f = cfg_data[pidff_pkg::GAIN_BITS-1:0];
                pidff_pkg::REG_DRIVE_MIN:
                    cfg_next.drive_min = cfg_data[pidff_pkg::DATA_BITS-1:0];
                pidff_pkg::REG_DRIVE_MAX:
                    cfg_next.drive_max = cfg_data[pidff_pkg::DATA_BITS-1:0];
                pidff_pkg::REG_INTEG_MIN:
                    cfg_next.integ_min = cfg_data[pidff_pkg::DATA_BITS-1:0];
                pidff_pkg::REG_INTEG_MAX:
                    cfg_next.integ_max = cfg_data[pidff_pkg::DATA_BITS-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p    <= '0;
            cfg_reg.gain_i    <= '0;
            cfg_reg.gain_d    <= '0;
            cfg_reg.gain_f    <= '0;
            cfg_reg.drive_min <= pidff_pkg::DATA_MIN;
            cfg_reg.drive_max <= pidff_pkg::DATA_MAX;
            cfg_reg.integ_min <= pidff_pkg::DATA_MIN;
            cfg_reg.integ_max <= pidff_pkg::DATA_MAX;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: design/pidff_front.sv
`default_nettype none
module pidff_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                en,
    input  wire logic                s_valid,
    input  wire pidff_pkg::in_beat_t s_data,
    input  wire pidff_pkg::cfg_t     cfg,
    output logic                     s2_emit,
    output logic                     s2_load,
    output pidff_pkg::stage2_t       s2,
    output pidff_pkg::front_stat_t   stat
);

    logic                in_valid_reg;
    pidff_pkg::in_beat_t in_reg;
    logic                running_reg;
    logic                running_next;
    pidff_pkg::err_t     prev_error_reg;
    pidff_pkg::err_t     prev_error_next;
    logic                s2_emit_reg;
    logic                s2_load_reg;
    pidff_pkg::stage2_t  s2_reg;
    pidff_pkg::stage2_t  s2_next;

    logic                emit;
    logic                load;
    logic                gains_zero;
    pidff_pkg::err_t     err;
    pidff_pkg::diff_t    diff;

    logic signed [pidff_pkg::GAIN_BITS+pidff_pkg::ERR_BITS:0]   p_prod;
    logic signed [pidff_pkg::GAIN_BITS+pidff_pkg::ERR_BITS:0]   i_prod;
    logic signed [pidff_pkg::GAIN_BITS+pidff_pkg::DIFF_BITS:0]  d_prod;
    logic signed [pidff_pkg::GAIN_BITS+pidff_pkg::DATA_BITS:0]  f_prod;

    assign gains_zero = (cfg.gain_p == '0) && (cfg.gain_i == '0);

    assign err  = pidff_pkg::err_t'(in_reg.setpoint) - pidff_pkg::err_t'(in_reg.measurement);
    assign diff = pidff_pkg::diff_t'(err) - pidff_pkg::diff_t'(prev_error_reg);

    assign p_prod = $signed({1'b0, cfg.gain_p}) * err;
    assign i_prod = $signed({1'b0, cfg.gain_i}) * err;
    assign d_prod = $signed({1'b0, cfg.gain_d}) * diff;
    assign f_prod = $signed({1'b0, cfg.gain_f}) * in_reg.measurement;

    // Item decode and the running / previous error state.
    always_comb begin
        emit            = 1'b0;
        load            = 1'b0;
        running_next    = running_reg;
        prev_error_next = prev_error_reg;
        if (in_valid_reg && en) begin
            case (in_reg.func)
                pidff_pkg::FUNC_SAMPLE: begin
                    if (running_reg) begin
                        emit            = 1'b1;
                        prev_error_next = err;
                    end
                end
                pidff_pkg::FUNC_ENABLE: begin
                    if (!gains_zero) begin
                        if (!running_reg) begin
                            load            = 1'b1;
                            prev_error_next = err;
                        end
                        running_next = 1'b1;
                    end
                end
                pidff_pkg::FUNC_DISABLE: running_next = 1'b0;
                default: running_next = running_reg;
            endcase
        end
        // Both P and I gains written to zero while running stop the loop.
        if (gains_zero) begin
            running_next = 1'b0;
        end
    end

    always_comb begin
        s2_next.p_term  = pidff_pkg::sat_acc(pidff_pkg::wide_t'(p_prod));
        s2_next.i_prod  = pidff_pkg::wide_t'(i_prod);
        s2_next.d_term  = pidff_pkg::sat_acc(pidff_pkg::wide_t'(d_prod));
        s2_next.f_term  = pidff_pkg::sat_acc(pidff_pkg::wide_t'(f_prod));
        s2_next.preload = in_reg.preload;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            running_reg    <= 1'b0;
            prev_error_reg <= '0;
            s2_emit_reg    <= 1'b0;
            s2_load_reg    <= 1'b0;
        end else begin
            running_reg    <= running_next;
            prev_error_reg <= prev_error_next;
            if (en) begin
                in_valid_reg <= s_valid;
                s2_emit_reg  <= emit;
                s2_load_reg  <= load;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_valid) begin
            in_reg <= s_data;
        end
        if (en) begin
            s2_reg <= s2_next;
        end
    end

    assign s2_emit         = s2_emit_reg;
    assign s2_load         = s2_load_reg;
    assign s2              = s2_reg;
    assign stat.running    = running_reg;
    assign stat.gains_zero = gains_zero;

endmodule
`default_nettype wire

// File: design/pidff_integ.sv
`default_nettype none
module pidff_integ (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               s2_emit,
    input  wire logic               s2_load,
    input  wire pidff_pkg::stage2_t s2,
    input  wire pidff_pkg::cfg_t    cfg,
    output logic                    s3_emit,
    output pidff_pkg::terms_t       s3
);

    pidff_pkg::acc_t   integrator_reg;
    pidff_pkg::acc_t   integrator_next;
    logic              s3_emit_reg;
    pidff_pkg::terms_t s3_reg;
    pidff_pkg::terms_t s3_next;

    pidff_pkg::acc_t   imin_s;
    pidff_pkg::acc_t   imax_s;
    pidff_pkg::acc_t   ilo;
    pidff_pkg::acc_t   ihi;
    pidff_pkg::acc_t   acc_sat;
    pidff_pkg::acc_t   acc_clamped;

    assign imin_s = pidff_pkg::acc_t'(cfg.integ_min) <<< pidff_pkg::FRAC_BITS;
    assign imax_s = pidff_pkg::acc_t'(cfg.integ_max) <<< pidff_pkg::FRAC_BITS;
    assign ilo    = (imin_s < imax_s) ? imin_s : imax_s;
    assign ihi    = (imin_s < imax_s) ? imax_s : imin_s;

    assign acc_sat = pidff_pkg::sat_acc(pidff_pkg::wide_t'(integrator_reg) + s2.i_prod);

    // Upper limit first, then lower.
    always_comb begin
        acc_clamped = acc_sat;
        if (acc_clamped > ihi) begin
            acc_clamped = ihi;
        end
        if (acc_clamped < ilo) begin
            acc_clamped = ilo;
        end
    end

    always_comb begin
        integrator_next = integrator_reg;
        if (en && s2_load) begin
            integrator_next = pidff_pkg::sat_acc(
                pidff_pkg::wide_t'(s2.preload) <<< pidff_pkg::FRAC_BITS);
        end else if (en && s2_emit) begin
            integrator_next = acc_clamped;
        end
    end

    always_comb begin
        s3_next.p_term = s2.p_term;
        s3_next.i_term = acc_clamped;
        s3_next.d_term = s2.d_term;
        s3_next.f_term = s2.f_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integrator_reg <= '0;
            s3_emit_reg    <= 1'b0;
        end else begin
            integrator_reg <= integrator_next;
            if (en) begin
                s3_emit_reg <= s2_emit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_reg <= s3_next;
        end
    end

    assign s3_emit = s3_emit_reg;
    assign s3      = s3_reg;

endmodule
`default_nettype wire

// File: design/pidff_out.sv
`default_nettype none
module pidff_out (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire logic               s3_emit,
    input  wire pidff_pkg::terms_t  s3,
    input  wire pidff_pkg::cfg_t    cfg,
    output logic                    out_valid,
    output pidff_pkg::out_beat_t    out_data
);

    logic                 out_valid_reg;
    pidff_pkg::out_beat_t out_data_reg;
    pidff_pkg::out_beat_t out_data_next;

    pidff_pkg::wide_t sum;
    pidff_pkg::wide_t sum_signed;
    pidff_pkg::wide_t scaled;
    pidff_pkg::wide_t dmin_w;
    pidff_pkg::wide_t dmax_w;
    pidff_pkg::wide_t dlo;
    pidff_pkg::wide_t dhi;
    pidff_pkg::wide_t clamped;

    assign sum = pidff_pkg::wide_t'(s3.p_term) + pidff_pkg::wide_t'(s3.i_term)
               + pidff_pkg::wide_t'(s3.d_term) + pidff_pkg::wide_t'(s3.f_term);
    assign sum_signed = pidff_pkg::INVERTED ? -sum : sum;
    // Arithmetic shift gives the floor of the division.
    assign scaled = sum_signed >>> pidff_pkg::FRAC_BITS;

    assign dmin_w = pidff_pkg::wide_t'(cfg.drive_min);
    assign dmax_w = pidff_pkg::wide_t'(cfg.drive_max);
    assign dlo    = (dmin_w < dmax_w) ? dmin_w : dmax_w;
    assign dhi    = (dmin_w < dmax_w) ? dmax_w : dmin_w;

    always_comb begin
        clamped = scaled;
        if (clamped > dhi) begin
            clamped = dhi;
        end
        if (clamped < dlo) begin
            clamped = dlo;
        end
    end

    always_comb begin
        out_data_next.drive  = clamped[pidff_pkg::DATA_BITS-1:0];
        out_data_next.p_term = s3.p_term;
        out_data_next.i_term = s3.i_term;
        out_data_next.d_term = s3.d_term;
        out_data_next.f_term = s3.f_term;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= s3_emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s3_emit) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// File: design/pid_feedforward_controller.sv
`default_nettype none
// PID controller with feed-forward on the measurement, in Q.8 fixed point.
// Each input beat carries a function code: a sample produces one result beat
// while the loop is enabled, an enable loads the integrator from the preload
// field for bumpless transfer (refused while both gain_p and gain_i are
// zero, ignored if already enabled), and a disable stops the loop; enable,
// disable, the unused code and samples while disabled produce no result.
// The block is a four-register pipeline (input register, product stage,
// integrator stage, output register) and takes one beat every cycle
// while not stalled. The previous error is updated in place in the product
// stage and the integrator in the integrator stage, so consecutive samples
// need no spacing. All stages stall together only while a result beat
// waits in the output register and m_ready is low. Configuration writes
// are taken every cycle and must be made while no sample is in flight.
// Writing both gain_p and gain_i to zero while enabled disables the loop.
// A min/max limit pair written in reverse order acts as the swapped pair.
// There is no clearing pass after reset.
module pid_feedforward_controller (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,

    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire pidff_pkg::in_beat_t              s_data,

    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output pidff_pkg::out_beat_t                  m_data,

    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire pidff_pkg::reg_idx_t              cfg_index,
    input  wire logic [pidff_pkg::CFG_BITS-1:0]   cfg_data
);

    pidff_pkg::cfg_t        cfg;
    pidff_pkg::stage2_t     s2;
    pidff_pkg::terms_t      s3;
    pidff_pkg::front_stat_t stat;
    logic                   s2_emit;
    logic                   s2_load;
    logic                   s3_emit;
    logic                   out_valid;
    logic                   en;

    // The whole pipeline moves whenever the output register is free or its
    // beat is being taken this cycle.
    assign en        = !out_valid || m_ready;
    assign s_ready   = en;
    assign m_valid   = out_valid;
    // Register writes never stall.
    assign cfg_ready = 1'b1;

    pidff_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidff_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s_valid (s_valid),
        .s_data  (s_data),
        .cfg     (cfg),
        .s2_emit (s2_emit),
        .s2_load (s2_load),
        .s2      (s2),
        .stat    (stat)
    );

    pidff_integ u_integ (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .s2_emit (s2_emit),
        .s2_load (s2_load),
        .s2      (s2),
        .cfg     (cfg),
        .s3_emit (s3_emit),
        .s3      (s3)
    );

    pidff_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .s3_emit   (s3_emit),
        .s3        (s3),
        .cfg       (cfg),
        .out_valid (out_valid),
        .out_data  (m_data)
    );

    // With both P and I gains at zero the loop must be disabled by the next
    // cycle.
    a_gains_zero_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.gains_zero |=> !stat.running)
        else $error("loop still running with zero P and I gains");

    // A result beat only appears after a sample passed the integrator stage.
    a_result_from_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s3_emit))
        else $error("result beat without a sample behind it");

    // An item is either an integrator load or a sample, never both.
    a_load_or_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s2_emit && s2_load))
        else $error("integrator load and sample in the same stage");

endmodule
`default_nettype wire

// File: dv/tb_pid_feedforward_controller.sv
`timescale 1ns / 1ps

// Self-checking bench for the PID controller with feed-forward.
// A behavioral model of the controller runs next to the block. Every input beat
// that the block takes is fed to the model at the same edge, and each result
// beat that the model predicts waits in a queue. The checker compares every
// result beat the block returns against the oldest beat in that queue.
module tb_pid_feedforward_controller;

    import pidff_pkg::*;

    // The block leaves code 3 of the function field unused and must ignore it.
    localparam func_t FUNC_UNUSED = 2'd3;

    // One in Q.FRAC_BITS. It scales the preload and the integrator limits.
    localparam longint Q_ONE = longint'(1) << FRAC_BITS;

    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 175;
    localparam int PRESSURE_PHASE = 3;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES    = 400;
    // Wait after the last result, so that beats giving no result leave the pipeline.
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int unsigned LIMIT = 600000;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    reg_idx_t    cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    pid_feedforward_controller i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Controller model: its own copy of the registers and of the loop state.
    // ------------------------------------------------------------------
    gain_t  k_p, k_i, k_d, k_f;
    data_t  drv_lo, drv_hi, integ_lo, integ_hi;
    acc_t   integ_q;
    err_t   prev_err_q;
    logic   run_q;

    // Result beats the model has predicted and the block has not yet returned.
    out_beat_t predicted_beats_q[$];

    int unsigned n_fail = 0;
    int unsigned cycle_cnt = 0;

    // Idle rates in percent for the sender and the receiver, and the count of
    // long receiver hold-offs that have been requested so far.
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_reqs = 0;

    function automatic longint limit_acc(longint x);
        longint hi;
        hi = (longint'(1) << (ACC_BITS - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    // Clamps to a limit pair. A pair written in reverse order counts as swapped.
    function automatic longint clamp_pair(longint x, longint a, longint b);
        longint lo, hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x;
    endfunction

    function automatic void pid_reset();
        k_p        = '0;
        k_i        = '0;
        k_d        = '0;
        k_f        = '0;
        drv_lo     = DATA_MIN;
        drv_hi     = DATA_MAX;
        integ_lo   = DATA_MIN;
        integ_hi   = DATA_MAX;
        integ_q    = '0;
        prev_err_q = '0;
        run_q      = 1'b0;
    endfunction

    function automatic void pid_write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] val);
        case (idx)
            REG_GAIN_P:    k_p = val;
            REG_GAIN_I:    k_i = val;
            REG_GAIN_D:    k_d = val;
            REG_GAIN_F:    k_f = val;
            REG_DRIVE_MIN: drv_lo = val;
            REG_DRIVE_MAX: drv_hi = val;
            REG_INTEG_MIN: integ_lo = val;
            REG_INTEG_MAX: integ_hi = val;
            default: ;
        endcase
        // If a gain write leaves both gain_p and gain_i at zero, the loop stops.
        if (idx <= REG_GAIN_F && k_p == '0 && k_i == '0) begin
            run_q = 1'b0;
        end
    endfunction

    // Advances the model by one input beat. Returns 1 and the result when
    // the beat produces one.
    function automatic bit pid_step(input in_beat_t b, output out_beat_t r);
        longint err, pt, integ, dt, ft, sum, drv;
        r = '0;
        if (b.func == FUNC_ENABLE) begin
            // Bumpless start: the integrator takes the current drive. An enable
            // while both gains are zero, or while already running, does nothing.
            if (k_p != '0 || k_i != '0) begin
                if (!run_q) begin
                    integ_q    = acc_t'(limit_acc(longint'(b.preload) * Q_ONE));
                    prev_err_q = err_t'(longint'(b.setpoint) - longint'(b.measurement));
                end
                run_q = 1'b1;
            end
            return 1'b0;
        end
        if (b.func == FUNC_DISABLE) begin
            run_q = 1'b0;
            return 1'b0;
        end
        if (b.func != FUNC_SAMPLE || !run_q) return 1'b0;

        err   = longint'(b.setpoint) - longint'(b.measurement);
        pt    = limit_acc(longint'(k_p) * err);
        integ = limit_acc(longint'(integ_q) + longint'(k_i) * err);
        integ = clamp_pair(integ, longint'(integ_lo) * Q_ONE, longint'(integ_hi) * Q_ONE);
        dt    = limit_acc(longint'(k_d) * (err - longint'(prev_err_q)));
        ft    = limit_acc(longint'(k_f) * longint'(b.measurement));
        integ_q    = integ[ACC_BITS-1:0];
        prev_err_q = err[ERR_BITS-1:0];

        // The four saturated terms are summed exactly. The arithmetic shift
        // floors the sum back into sample units.
        sum = pt + integ + dt + ft;
        if (INVERTED) sum = -sum;
        drv = clamp_pair(sum >>> FRAC_BITS, longint'(drv_lo), longint'(drv_hi));

        r.drive  = drv[DATA_BITS-1:0];
        r.p_term = pt[ACC_BITS-1:0];
        r.i_term = integ[ACC_BITS-1:0];
        r.d_term = dt[ACC_BITS-1:0];
        r.f_term = ft[ACC_BITS-1:0];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random values, weighted toward the extremes and toward small values
    // near zero, where the saturation and clamping cases lie.
    // ------------------------------------------------------------------
    function automatic data_t rand_data();
        case ($urandom_range(0, 9))
            0:       return DATA_MIN;
            1:       return DATA_MAX;
            2, 3, 4: return data_t'($urandom_range(0, 600)) - data_t'(300);
            default: return data_t'($urandom);
        endcase
    endfunction

    function automatic gain_t rand_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return gain_t'(Q_ONE);
            3:       return gain_t'($urandom_range(1, 512));
            default: return gain_t'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Every input changes only through nonblocking assignments at
    // the rising edge. The code that waits for a handshake samples ready at the
    // same edge, and so it sees the value ready had during the cycle just ended.
    // ------------------------------------------------------------------

    // Offers one input beat, after a random idle burst now and then. When the
    // block takes the beat, the model is advanced at that edge. A row with a
    // known result puts that result on the queue instead of the model's.
    task automatic push_item(input in_beat_t b, input bit known, input out_beat_t want);
        out_beat_t r;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        do @(posedge aclk); while (!s_ready);
        if (pid_step(b, r)) begin
            predicted_beats_q.push_back(known ? want : r);
        end
    endtask

    // Writes one register. When another write follows at once, valid stays
    // high, so that it is never lowered and raised again at the same edge.
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_BITS-1:0] val,
                             input bit more);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        pid_write_reg(idx, val);
        if (!more) begin
            cfg_valid <= 1'b0;
        end
    endtask

    // Brings the block to idle. The task waits until every predicted beat has
    // come back, then waits on so that beats that give no result can leave.
    task automatic settle();
        s_valid <= 1'b0;
        while (predicted_beats_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Directed table. Register rows are written only after the block has
    // settled. Rows with a known result carry values that can be worked out
    // by hand. All other rows are checked against the model.
    // ------------------------------------------------------------------
    typedef struct {
        bit                  is_reg;
        reg_idx_t            idx;
        logic [CFG_BITS-1:0] val;
        in_beat_t            beat;
        bit                  known;
        out_beat_t           want;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic void add_item(func_t f, data_t sp, data_t ms, data_t pl);
        dir_row_t row;
        row = '{default: '0};
        row.beat.func        = f;
        row.beat.setpoint    = sp;
        row.beat.measurement = ms;
        row.beat.preload     = pl;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_reg(reg_idx_t idx, logic [CFG_BITS-1:0] val);
        dir_row_t row;
        row = '{default: '0};
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        dir_rows.push_back(row);
    endfunction

    // A sample row whose only nonzero terms are P and the drive.
    function automatic void add_known(data_t sp, data_t ms, data_t drive, acc_t p);
        add_item(FUNC_SAMPLE, sp, ms, '0);
        dir_rows[$].known        = 1'b1;
        dir_rows[$].want.drive   = drive;
        dir_rows[$].want.p_term  = p;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: each accepted result beat is compared with the oldest
    // predicted beat.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_beats_q.size() == 0) begin
                $error("unexpected result beat: drive %0d", m_data.drive);
                n_fail++;
            end else begin
                want = predicted_beats_q.pop_front();
                if (m_data.drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, m_data.drive);
                    n_fail++;
                end
                if (m_data.p_term !== want.p_term) begin
                    $error("p_term: expected %0d, got %0d", want.p_term, m_data.p_term);
                    n_fail++;
                end
                if (m_data.i_term !== want.i_term) begin
                    $error("i_term: expected %0d, got %0d", want.i_term, m_data.i_term);
                    n_fail++;
                end
                if (m_data.d_term !== want.d_term) begin
                    $error("d_term: expected %0d, got %0d", want.d_term, m_data.d_term);
                    n_fail++;
                end
                if (m_data.f_term !== want.f_term) begin
                    $error("f_term: expected %0d, got %0d", want.f_term, m_data.f_term);
                    n_fail++;
                end
            end
        end
    end

    // Receiver. It stalls in random bursts at the current rate. On request it
    // holds off for a long stretch, which backs the pipeline up to its input.
    initial begin : result_sink
        int stall_left;
        int holds_done;
        stall_left = 0;
        holds_done = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (holds_done != hold_reqs) begin
                holds_done++;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                stall_left = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog. The limit is several times the slowest correct run.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT) begin
            $display("tb_pid_feedforward_controller NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------
    initial begin : stimulus
        cfg_t      c;
        in_beat_t  b;
        data_t     sp_hold;
        int        pick;
        int        n_live;
        bit        was_running;
        int        idle_rates[4];

        idle_rates = '{0, 5, 20, 45};
        pid_reset();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_GAIN_P;
        cfg_data  <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset the loop is stopped and all gains are zero. So a sample
        // gives nothing, an enable is refused and the unused code is ignored.
        add_item(FUNC_SAMPLE, 5, 3, 0);
        add_item(FUNC_ENABLE, 0, 0, 0);
        add_item(FUNC_SAMPLE, 5, 3, 0);
        add_item(FUNC_UNUSED, DATA_MAX, DATA_MIN, DATA_MAX);
        // Unity P gain alone. The drive is the error, clamped to the data range.
        add_reg(REG_GAIN_P, 16'h0100);
        add_item(FUNC_ENABLE, 0, 0, 0);
        add_known(100, 0, 100, 25600);
        add_known(DATA_MAX, DATA_MIN, DATA_MAX, 32'sd16776960);
        add_known(DATA_MIN, DATA_MAX, DATA_MIN, -32'sd16776960);
        // Full-scale gains drive the P and D terms into saturation and the I term to its limit.
        add_reg(REG_GAIN_P, 16'hFFFF);
        add_reg(REG_GAIN_I, 16'hFFFF);
        add_reg(REG_GAIN_D, 16'hFFFF);
        add_reg(REG_GAIN_F, 16'hFFFF);
        add_item(FUNC_SAMPLE, DATA_MAX, DATA_MIN, 0);
        add_item(FUNC_SAMPLE, DATA_MIN, DATA_MAX, 0);
        add_item(FUNC_SAMPLE, 0, DATA_MIN, 0);
        add_item(FUNC_SAMPLE, 0, DATA_MAX, 0);
        // Tight limits. The drive pair is written in reverse order.
        add_reg(REG_DRIVE_MIN, 16'sd100);
        add_reg(REG_DRIVE_MAX, -16'sd100);
        add_reg(REG_INTEG_MIN, -16'sd10);
        add_reg(REG_INTEG_MAX, 16'sd10);
        add_item(FUNC_SAMPLE, 20, 10, 0);
        add_item(FUNC_SAMPLE, -20, 10, 0);
        // Both P and I gains go to zero while the loop runs, which stops it.
        add_reg(REG_GAIN_P, 16'h0000);
        add_reg(REG_GAIN_I, 16'h0000);
        add_item(FUNC_SAMPLE, 1, 2, 0);
        // Bumpless enable from a full-scale preload. A second enable must not
        // reload the integrator. Disable, then enable from the other extreme.
        add_reg(REG_GAIN_I, 16'h0001);
        add_item(FUNC_ENABLE, 0, 0, DATA_MAX);
        add_item(FUNC_ENABLE, DATA_MIN, DATA_MAX, DATA_MIN);
        add_item(FUNC_SAMPLE, 0, 0, 0);
        add_item(FUNC_DISABLE, 0, 0, 0);
        add_item(FUNC_SAMPLE, 7, 0, 0);
        add_item(FUNC_ENABLE, DATA_MIN, DATA_MAX, DATA_MIN);
        add_item(FUNC_SAMPLE, DATA_MIN, DATA_MAX, 0);

        src_idle_pct = 20;
        snk_idle_pct = 20;
        foreach (dir_rows[n]) begin
            if (dir_rows[n].is_reg) begin
                if (n == 0 || !dir_rows[n-1].is_reg) begin
                    settle();
                end
                write_reg(dir_rows[n].idx, dir_rows[n].val,
                          n + 1 < dir_rows.size() && dir_rows[n+1].is_reg);
            end else begin
                push_item(dir_rows[n].beat, dir_rows[n].known, dir_rows[n].want);
            end
        end

        // Random phases. Each phase writes all registers while the block is
        // idle. Phase 0 uses full-scale gains and full-range limits. Phase 1
        // uses the smallest gains and limit pairs collapsed to zero.
        sp_hold = '0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            c.gain_p = rand_gain();
            c.gain_i = rand_gain();
            c.gain_d = rand_gain();
            c.gain_f = rand_gain();
            if ($urandom_range(0, 2) == 0) begin
                c.drive_min = DATA_MIN;
                c.drive_max = DATA_MAX;
                c.integ_min = DATA_MIN;
                c.integ_max = DATA_MAX;
            end else begin
                c.drive_min = rand_data();
                c.drive_max = rand_data();
                c.integ_min = rand_data();
                c.integ_max = rand_data();
            end
            if (ph == 0) begin
                c = '{gain_p: '1, gain_i: '1, gain_d: '1, gain_f: '1,
                      drive_min: DATA_MIN, drive_max: DATA_MAX,
                      integ_min: DATA_MIN, integ_max: DATA_MAX};
            end else if (ph == 1) begin
                c = '{gain_p: 16'h0001, gain_i: 16'h0001, gain_d: 16'h0001,
                      gain_f: 16'h0001, default: '0};
            end
            // Most phases need a gain that lets the loop start.
            if ((c.gain_p == '0 && c.gain_i == '0 && $urandom_range(0, 9) != 0)
                    || ph == PRESSURE_PHASE) begin
                c.gain_p = gain_t'(Q_ONE);
            end
            write_reg(REG_GAIN_P,    c.gain_p,    1'b1);
            write_reg(REG_GAIN_I,    c.gain_i,    1'b1);
            write_reg(REG_GAIN_D,    c.gain_d,    1'b1);
            write_reg(REG_GAIN_F,    c.gain_f,    1'b1);
            write_reg(REG_DRIVE_MIN, c.drive_min, 1'b1);
            write_reg(REG_DRIVE_MAX, c.drive_max, 1'b1);
            write_reg(REG_INTEG_MIN, c.integ_min, 1'b1);
            write_reg(REG_INTEG_MAX, c.integ_max, 1'b0);

            // The last two phases run without idling on either side.
            if (ph >= NUM_PHASES - 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = idle_rates[$urandom_range(0, 3)];
                snk_idle_pct = idle_rates[$urandom_range(0, 3)];
            end

            // Back pressure: the receiver holds off for a long stretch while the
            // sender keeps offering samples without a break.
            if (ph == PRESSURE_PHASE) begin
                src_idle_pct = 0;
                b = '{func: FUNC_ENABLE, setpoint: '0, measurement: '0, preload: '0};
                push_item(b, 1'b0, '0);
                hold_reqs++;
                repeat (PRESSURE_ITEMS) begin
                    b = '{func: FUNC_SAMPLE, setpoint: rand_data(),
                          measurement: rand_data(), preload: rand_data()};
                    push_item(b, 1'b0, '0);
                end
                src_idle_pct = idle_rates[$urandom_range(0, 3)];
            end

            // Mostly well-formed traffic: an enable starts the loop, and then
            // comes a run of samples that track a slowly changing setpoint.
            // Disables, extra enables and unused codes are mixed in.
            n_live = 0;
            while (n_live < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 9) == 0) begin
                    sp_hold = rand_data();
                end
                b.setpoint = ($urandom_range(0, 3) == 0) ? rand_data() : sp_hold;
                if ($urandom_range(0, 2) == 0) begin
                    b.measurement = rand_data();
                end else begin
                    b.measurement = sp_hold + data_t'($urandom_range(0, 600)) - data_t'(300);
                end
                b.preload = rand_data();
                if (!run_q && pick < 85) begin
                    b.func = FUNC_ENABLE;
                end else if (pick < 3) begin
                    b.func = FUNC_DISABLE;
                end else if (pick < 6) begin
                    b.func = FUNC_ENABLE;
                end else if (pick < 8) begin
                    b.func = FUNC_UNUSED;
                end else begin
                    b.func = FUNC_SAMPLE;
                end
                was_running = run_q;
                push_item(b, 1'b0, '0);
                // Unused codes and samples while the loop is stopped, which the block only ignores, are not counted.
                if (b.func != FUNC_UNUSED && !(b.func == FUNC_SAMPLE && !was_running)) begin
                    n_live++;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_fail == 0) begin
            $display("tb_pid_feedforward_controller OK");
        end else begin
            $display("tb_pid_feedforward_controller NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/pidff_pkg.sv
design/pidff_cfg_regs.sv
design/pidff_front.sv
design/pidff_integ.sv
design/pidff_out.sv
design/pid_feedforward_controller.sv
dv/tb_pid_feedforward_controller.sv
